>>> rtl/core/sas_pkg.sv
// Shared types and constants for the sprite animation sequencer.
// Depends on nothing; every module of the block imports it.
package sas_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned APB_AW = 5;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_TICK   = 2'd1,
    OP_CHANGE = 2'd2,
    OP_DRAW   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_SKIN_INDEX   = 3'd0,
    REG_SKIN_STEP_X  = 3'd1,
    REG_SKIN_STEP_Y  = 3'd2,
    REG_FRAME_WIDTH  = 3'd3,
    REG_FRAME_HEIGHT = 3'd4,
    REG_SCALE        = 3'd5,
    REG_MIRROR       = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_WRITE,
    BK_READ1,
    BK_UPDATE,
    BK_MOD,
    BK_READ2,
    BK_MUL,
    BK_SUM
  } bk_state_e;

  typedef struct packed {
    logic [3:0]  skin_index;
    logic [12:0] skin_step_x;
    logic [12:0] skin_step_y;
    logic [11:0] frame_width;
    logic [11:0] frame_height;
    logic [3:0]  scale;
    logic        mirror;
  } cfg_t;

  typedef struct packed {
    logic [15:0] fx;
    logic [15:0] fy;
    logic [11:0] sdx;
    logic [11:0] sdy;
    logic [7:0]  count;
    logic [15:0] ticks;
    logic [2:0]  flags;
    logic [3:0]  next;
    logic [11:0] cw;
    logic [11:0] ch;
  } desc_t;

  typedef struct packed {
    op_e         op;
    logic [3:0]  sel;
    logic        slot_ok;
    logic [15:0] coord_x;
    logic [15:0] coord_y;
    logic [11:0] step_dx;
    logic [11:0] step_dy;
    logic [7:0]  frame_count;
    logic [15:0] frame_ticks;
    logic [2:0]  mode_flags;
    logic [3:0]  follow_anim;
    logic [11:0] custom_w;
    logic [11:0] custom_h;
  } item_t;

endpackage

>>> rtl/core/sas_front.sv
// Front stage: takes input items, classifies them and hands them to the queue.
// Depends on sas_pkg.
module sas_front #(
  parameter int unsigned ANIM_SLOTS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           op_i,
  input  logic [3:0]           anim_sel_i,
  input  logic [15:0]          coord_x_i,
  input  logic [15:0]          coord_y_i,
  input  logic [11:0]          step_dx_i,
  input  logic [11:0]          step_dy_i,
  input  logic [7:0]           frame_count_i,
  input  logic [15:0]          frame_ticks_i,
  input  logic [2:0]           mode_flags_i,
  input  logic [3:0]           follow_anim_i,
  input  logic [11:0]          custom_w_i,
  input  logic [11:0]          custom_h_i,
  output sas_pkg::item_t       item_o,
  output logic                 item_valid_o,
  input  logic                 item_ready_i
);
  import sas_pkg::*;

  item_t      item_q, item_d;
  logic       valid_q, valid_d;
  logic       accept;
  logic [8:0] sel_wide;

  assign in_stall_o   = valid_q && !item_ready_i;
  assign accept       = in_valid_i && !in_stall_o;
  assign item_o       = item_q;
  assign item_valid_o = valid_q;
  assign sel_wide     = {5'b0, anim_sel_i};

  always_comb begin
    item_d             = item_q;
    valid_d            = valid_q && !item_ready_i;
    if (accept) begin
      valid_d            = 1'b1;
      item_d.op          = op_e'(op_i);
      item_d.sel         = anim_sel_i;
      // A load to a slot past the table is dropped later.
      item_d.slot_ok     = sel_wide < 9'(ANIM_SLOTS);
      item_d.coord_x     = coord_x_i;
      item_d.coord_y     = coord_y_i;
      item_d.step_dx     = step_dx_i;
      item_d.step_dy     = step_dy_i;
      item_d.frame_count = frame_count_i;
      item_d.frame_ticks = frame_ticks_i;
      item_d.mode_flags  = mode_flags_i;
      item_d.follow_anim = follow_anim_i;
      item_d.custom_w    = custom_w_i;
      item_d.custom_h    = custom_h_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

>>> rtl/core/sas_queue.sv
// Two-entry item queue between the front and back stages.
// Depends on sas_pkg.
module sas_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sas_pkg::item_t push_item_i,
  input  logic           push_i,
  output logic           ready_o,
  output sas_pkg::item_t pop_item_o,
  output logic           not_empty_o,
  input  logic           pop_i
);
  import sas_pkg::*;

  item_t      entry_q [QDEPTH];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign ready_o     = count_q != 2'(QDEPTH);
  assign not_empty_o = count_q != 2'd0;
  assign pop_item_o  = entry_q[rd_ptr_q];
  assign do_push     = push_i && ready_o;
  assign do_pop      = pop_i && not_empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

>>> rtl/core/sas_back.sv
// Back stage: descriptor memory, animation state, frame arithmetic and result register.
// Depends on sas_pkg.
module sas_back #(
  parameter int unsigned ANIM_SLOTS = 16,
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sas_pkg::cfg_t  cfg_i,
  input  sas_pkg::item_t q_item_i,
  input  logic           q_not_empty_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [15:0]    src_x_o,
  output logic [15:0]    src_y_o,
  output logic [11:0]    src_w_o,
  output logic [11:0]    src_h_o,
  output logic [15:0]    dst_x_o,
  output logic [15:0]    dst_y_o,
  output logic [15:0]    dst_w_o,
  output logic [15:0]    dst_h_o,
  output logic           mirror_out_o,
  output logic [3:0]     anim_now_o,
  output logic [7:0]     frame_now_o,
  output logic           frame_error_o
);
  import sas_pkg::*;

  localparam int unsigned SLOT_AW = $clog2(ANIM_SLOTS);
  localparam int unsigned CMP_W   = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  bk_state_e state_q, state_d;

  // Control strobes from the sequencer.
  logic mem_we, rd_en, upd_en, mod_en, mul_en, sum_en, out_free;

  desc_t              mem_q [ANIM_SLOTS];
  desc_t              rdata_q;
  logic               rd_ok_q;
  desc_t              desc_cur;
  logic [8:0]         wr_wide, rd_wide;

  item_t              cur_q;
  logic [3:0]         anim_q, anim_d;
  logic [7:0]         frame_q, frame_d;
  logic               rev_q, rev_d;
  logic [TIMER_BITS-1:0] el_q, el_d, el_inc;
  logic               err_q, err_d;
  logic               mod_start;

  logic [8:0]         mod_rem_q, mod_dvd_q, mod_t, mod_rem_next;
  logic [7:0]         mod_div_q;
  logic [3:0]         mod_cnt_q;
  logic               mod_done;

  logic signed [20:0] prod_x_q, prod_y_q;
  logic signed [17:0] skin_x_q, skin_y_q;
  logic [15:0]        fx_q, fy_q;
  logic [11:0]        w_q, h_q, w_sel, h_sel;
  logic [15:0]        dw_q, dh_q;
  logic signed [22:0] sx, sy;

  logic               out_valid_q;
  logic [15:0]        src_x_q, src_y_q, dst_x_q, dst_y_q, dst_w_q, dst_h_q;
  logic [11:0]        src_w_q, src_h_q;
  logic               mirror_q, ferr_q;
  logic [3:0]         anim_o_q;
  logic [7:0]         frame_o_q;

  assign out_free = !out_valid_q || !out_stall_i;
  assign mod_done = mod_cnt_q == 4'd0;

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE:   if (q_not_empty_i) state_d = BK_WRITE;
      BK_WRITE:  state_d = BK_READ1;
      BK_READ1:  state_d = BK_UPDATE;
      BK_UPDATE: state_d = mod_start ? BK_MOD : BK_READ2;
      BK_MOD:    if (mod_done) state_d = BK_READ2;
      BK_READ2:  state_d = BK_MUL;
      BK_MUL:    state_d = BK_SUM;
      BK_SUM:    if (out_free) state_d = BK_IDLE;
      default:   state_d = BK_IDLE;
    endcase
  end

  // Sequencer: strobes.
  always_comb begin
    q_pop_o = 1'b0;
    mem_we  = 1'b0;
    rd_en   = 1'b0;
    upd_en  = 1'b0;
    mod_en  = 1'b0;
    mul_en  = 1'b0;
    sum_en  = 1'b0;
    case (state_q)
      BK_IDLE:   q_pop_o = q_not_empty_i;
      BK_WRITE:  mem_we  = (cur_q.op == OP_LOAD) && cur_q.slot_ok;
      BK_READ1:  rd_en   = 1'b1;
      BK_UPDATE: upd_en  = 1'b1;
      BK_MOD:    mod_en  = 1'b1;
      BK_READ2:  rd_en   = 1'b1;
      BK_MUL:    mul_en  = 1'b1;
      BK_SUM:    sum_en  = out_free;
      default:   q_pop_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Descriptor memory, one write and one registered read port.
  assign wr_wide = {5'b0, cur_q.sel};
  assign rd_wide = {5'b0, anim_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_wide[SLOT_AW-1:0]] <= '{fx: cur_q.coord_x, fy: cur_q.coord_y,
                                       sdx: cur_q.step_dx, sdy: cur_q.step_dy,
                                       count: cur_q.frame_count,
                                       ticks: cur_q.frame_ticks,
                                       flags: cur_q.mode_flags,
                                       next: cur_q.follow_anim,
                                       cw: cur_q.custom_w, ch: cur_q.custom_h};
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_wide[SLOT_AW-1:0]];
      rd_ok_q <= rd_wide < 9'(ANIM_SLOTS);
    end
  end

  // An animation beyond the table behaves as an all-zero descriptor.
  assign desc_cur = rd_ok_q ? rdata_q : '0;

  // State update for tick and change items.
  always_comb begin
    anim_d    = anim_q;
    frame_d   = frame_q;
    rev_d     = rev_q;
    el_d      = el_q;
    err_d     = 1'b0;
    mod_start = 1'b0;
    el_inc    = (el_q == {TIMER_BITS{1'b1}}) ? el_q : el_q + 1'b1;
    if (cur_q.op == OP_TICK) begin
      el_d = el_inc;
      if (CMP_W'(el_inc) > CMP_W'(desc_cur.ticks)) begin
        el_d = '0;
        if (desc_cur.flags[0] && ({1'b0, frame_q} + 9'd1 >= {1'b0, desc_cur.count})) begin
          anim_d  = desc_cur.next;
          frame_d = 8'd0;
        end else if (desc_cur.count == 8'd0) begin
          frame_d = 8'd0;
          err_d   = 1'b1;
        end else if (desc_cur.flags[1]) begin
          if (desc_cur.count == 8'd1) begin
            frame_d = 8'd0;
            rev_d   = 1'b0;
          end else begin
            if ((!rev_q && ({1'b0, frame_q} + 9'd1 >= {1'b0, desc_cur.count})) ||
                (rev_q && frame_q == 8'd0)) begin
              rev_d = !rev_q;
            end
            frame_d = rev_d ? frame_q - 8'd1 : frame_q + 8'd1;
          end
        end else if ({1'b0, frame_q} + 9'd1 < {1'b0, desc_cur.count}) begin
          frame_d = frame_q + 8'd1;
        end else begin
          // Wrap past the end: remainder unit takes over the frame.
          mod_start = 1'b1;
        end
      end
    end else if (cur_q.op == OP_CHANGE) begin
      if (!desc_cur.flags[0] && anim_q != cur_q.sel) begin
        anim_d  = cur_q.sel;
        frame_d = 8'd0;
        el_d    = '0;
      end
    end
  end

  // Restoring remainder, one dividend bit per cycle.
  assign mod_t        = {mod_rem_q[7:0], mod_dvd_q[8]};
  assign mod_rem_next = (mod_t >= {1'b0, mod_div_q}) ? mod_t - {1'b0, mod_div_q} : mod_t;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anim_q  <= 4'd0;
      frame_q <= 8'd0;
      rev_q   <= 1'b0;
      el_q    <= '0;
      err_q   <= 1'b0;
    end else begin
      if (q_pop_o) begin
        err_q <= 1'b0;
      end
      if (upd_en) begin
        anim_q  <= anim_d;
        frame_q <= frame_d;
        rev_q   <= rev_d;
        el_q    <= el_d;
        err_q   <= err_d;
      end
      if (mod_en && mod_done) begin
        frame_q <= mod_rem_next[7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_item_i;
    end
    if (upd_en && mod_start) begin
      mod_rem_q <= 9'd0;
      mod_dvd_q <= {1'b0, frame_q} + 9'd1;
      mod_div_q <= desc_cur.count;
      mod_cnt_q <= 4'd8;
    end else if (mod_en) begin
      mod_rem_q <= mod_rem_next;
      mod_dvd_q <= {mod_dvd_q[7:0], 1'b0};
      mod_cnt_q <= mod_cnt_q - 4'd1;
    end
  end

  // Products for the source position and destination size.
  assign w_sel = desc_cur.flags[2] ? desc_cur.cw : cfg_i.frame_width;
  assign h_sel = desc_cur.flags[2] ? desc_cur.ch : cfg_i.frame_height;

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_x_q <= 21'($signed(desc_cur.sdx)) * 21'($signed({1'b0, frame_q}));
      prod_y_q <= 21'($signed(desc_cur.sdy)) * 21'($signed({1'b0, frame_q}));
      skin_x_q <= 18'($signed({1'b0, cfg_i.skin_index})) * 18'($signed(cfg_i.skin_step_x));
      skin_y_q <= 18'($signed({1'b0, cfg_i.skin_index})) * 18'($signed(cfg_i.skin_step_y));
      fx_q     <= desc_cur.fx;
      fy_q     <= desc_cur.fy;
      w_q      <= w_sel;
      h_q      <= h_sel;
      dw_q     <= 16'(w_sel) * 16'(cfg_i.scale);
      dh_q     <= 16'(h_sel) * 16'(cfg_i.scale);
    end
  end

  assign sx = 23'($signed(fx_q)) + 23'(prod_x_q) + 23'(skin_x_q);
  assign sy = 23'($signed(fy_q)) + 23'(prod_y_q) + 23'(skin_y_q);

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (sum_en) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_en) begin
      src_x_q   <= (sx < 0) ? 16'd0 : ((sx > 23'sd65535) ? 16'hFFFF : sx[15:0]);
      src_y_q   <= (sy < 0) ? 16'd0 : ((sy > 23'sd65535) ? 16'hFFFF : sy[15:0]);
      src_w_q   <= w_q;
      src_h_q   <= h_q;
      dst_x_q   <= (cur_q.op == OP_DRAW) ? cur_q.coord_x : 16'd0;
      dst_y_q   <= (cur_q.op == OP_DRAW) ? cur_q.coord_y : 16'd0;
      dst_w_q   <= dw_q;
      dst_h_q   <= dh_q;
      mirror_q  <= cfg_i.mirror;
      anim_o_q  <= anim_q;
      frame_o_q <= frame_q;
      ferr_q    <= err_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign src_x_o       = src_x_q;
  assign src_y_o       = src_y_q;
  assign src_w_o       = src_w_q;
  assign src_h_o       = src_h_q;
  assign dst_x_o       = dst_x_q;
  assign dst_y_o       = dst_y_q;
  assign dst_w_o       = dst_w_q;
  assign dst_h_o       = dst_h_q;
  assign mirror_out_o  = mirror_q;
  assign anim_now_o    = anim_o_q;
  assign frame_now_o   = frame_o_q;
  assign frame_error_o = ferr_q;

  // A new result appears only out of the final arithmetic step.
  a_result_from_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == BK_SUM))
    else $error("result raised outside the final step");

  // The error flag only ever comes from a tick item.
  a_err_only_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> cur_q.op == OP_TICK)
    else $error("frame error on a non-tick item");

  // The partial remainder stays below the divisor while the unit runs.
  a_mod_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_MOD |-> mod_rem_q < {1'b0, mod_div_q})
    else $error("remainder out of range");

  // Items are taken from the queue only when the sequencer is free.
  a_pop_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> state_q == BK_WRITE)
    else $error("queue popped without starting an item");

endmodule

>>> rtl/core/sprite_animation_sequencer.sv
// Top level of the sprite animation sequencer: configuration registers and stage wiring.
// Depends on sas_pkg, sas_front, sas_queue and sas_back.
//
//  Channel  | Handshake                    | Payload
//  ---------+------------------------------+----------------------------------------
//  input    | in_valid_i / in_stall_o      | op_i, anim_sel_i, coord, step, descriptor
//  result   | out_valid_o / out_stall_i    | src rect, dst pos/size, mirror, anim, frame
//  config   | psel/penable/pwrite/pready   | paddr (byte 4*index), pwdata, prdata
//
// Each item passes through the back stage: the cycle that pops it from the
// queue, a memory write slot, two descriptor reads (before and after the state
// update), the update, a multiply stage and the final add and saturate, which waits
// while a finished result is held by out_stall_i. A tick that wraps a frame past the
// end of its animation also passes through the bit-serial remainder unit.
// The front stage and the two-entry queue keep taking items, until both are full,
// while the back stage works or while a finished result waits on out_stall_i.
// Reset clears the animation state and queue and loads the configuration defaults;
// the descriptor table is not cleared and a slot must be loaded before it is used.
module sprite_animation_sequencer #(
  parameter int unsigned ANIM_SLOTS = 16,
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sas_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 op_i,
  input  logic [3:0]                 anim_sel_i,
  input  logic [15:0]                coord_x_i,
  input  logic [15:0]                coord_y_i,
  input  logic [11:0]                step_dx_i,
  input  logic [11:0]                step_dy_i,
  input  logic [7:0]                 frame_count_i,
  input  logic [15:0]                frame_ticks_i,
  input  logic [2:0]                 mode_flags_i,
  input  logic [3:0]                 follow_anim_i,
  input  logic [11:0]                custom_w_i,
  input  logic [11:0]                custom_h_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [15:0]                src_x_o,
  output logic [15:0]                src_y_o,
  output logic [11:0]                src_w_o,
  output logic [11:0]                src_h_o,
  output logic [15:0]                dst_x_o,
  output logic [15:0]                dst_y_o,
  output logic [15:0]                dst_w_o,
  output logic [15:0]                dst_h_o,
  output logic                       mirror_out_o,
  output logic [3:0]                 anim_now_o,
  output logic [7:0]                 frame_now_o,
  output logic                       frame_error_o
);
  import sas_pkg::*;

  cfg_t     cfg_q, cfg_d;
  cfg_reg_e reg_sel;
  logic     cfg_we;

  item_t    front_item, q_item;
  logic     front_valid, q_ready, q_not_empty, q_pop;

  // The bus never waits; a write lands in the access phase.
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_sel = cfg_reg_e'(paddr[4:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      case (reg_sel)
        REG_SKIN_INDEX:   cfg_d.skin_index   = pwdata[3:0];
        REG_SKIN_STEP_X:  cfg_d.skin_step_x  = pwdata[12:0];
        REG_SKIN_STEP_Y:  cfg_d.skin_step_y  = pwdata[12:0];
        REG_FRAME_WIDTH:  cfg_d.frame_width  = pwdata[11:0];
        REG_FRAME_HEIGHT: cfg_d.frame_height = pwdata[11:0];
        REG_SCALE:        cfg_d.scale        = pwdata[3:0];
        REG_MIRROR:       cfg_d.mirror       = pwdata[0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  // Read data returns the stored bits, zero-extended.
  always_comb begin
    case (reg_sel)
      REG_SKIN_INDEX:   prdata = {28'd0, cfg_q.skin_index};
      REG_SKIN_STEP_X:  prdata = {19'd0, cfg_q.skin_step_x};
      REG_SKIN_STEP_Y:  prdata = {19'd0, cfg_q.skin_step_y};
      REG_FRAME_WIDTH:  prdata = {20'd0, cfg_q.frame_width};
      REG_FRAME_HEIGHT: prdata = {20'd0, cfg_q.frame_height};
      REG_SCALE:        prdata = {28'd0, cfg_q.scale};
      REG_MIRROR:       prdata = {31'd0, cfg_q.mirror};
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{skin_index: 4'd0, skin_step_x: 13'd0, skin_step_y: 13'd0,
                 frame_width: 12'd16, frame_height: 12'd16, scale: 4'd1,
                 mirror: 1'b0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sas_front #(
    .ANIM_SLOTS(ANIM_SLOTS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .anim_sel_i   (anim_sel_i),
    .coord_x_i    (coord_x_i),
    .coord_y_i    (coord_y_i),
    .step_dx_i    (step_dx_i),
    .step_dy_i    (step_dy_i),
    .frame_count_i(frame_count_i),
    .frame_ticks_i(frame_ticks_i),
    .mode_flags_i (mode_flags_i),
    .follow_anim_i(follow_anim_i),
    .custom_w_i   (custom_w_i),
    .custom_h_i   (custom_h_i),
    .item_o       (front_item),
    .item_valid_o (front_valid),
    .item_ready_i (q_ready)
  );

  sas_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_item_i(front_item),
    .push_i     (front_valid),
    .ready_o    (q_ready),
    .pop_item_o (q_item),
    .not_empty_o(q_not_empty),
    .pop_i      (q_pop)
  );

  sas_back #(
    .ANIM_SLOTS(ANIM_SLOTS),
    .TIMER_BITS(TIMER_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_item_i     (q_item),
    .q_not_empty_i(q_not_empty),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .src_x_o      (src_x_o),
    .src_y_o      (src_y_o),
    .src_w_o      (src_w_o),
    .src_h_o      (src_h_o),
    .dst_x_o      (dst_x_o),
    .dst_y_o      (dst_y_o),
    .dst_w_o      (dst_w_o),
    .dst_h_o      (dst_h_o),
    .mirror_out_o (mirror_out_o),
    .anim_now_o   (anim_now_o),
    .frame_now_o  (frame_now_o),
    .frame_error_o(frame_error_o)
  );

endmodule
